// ----- hw/rtl/ipd_pkg.sv -----
// Package for the incremental PD speed regulator.
// Holds field widths, register indexes and fixed constants shared by the RTL.
// No dependencies.
package ipd_pkg;

    // Field and register widths
    localparam int SPEED_W   = 14;
    localparam int DIV_W     = 12;
    localparam int DRIVE_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 14;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 32;

    // Fraction bits appended to each dividend, and the quotient width of the divider
    localparam int FRAC_SHIFT = 16;
    localparam int QUO_W      = SPEED_W + FRAC_SHIFT;

    // Drive ceiling
    localparam logic signed [DRIVE_W-1:0] DRIVE_CEILING = 16'sd800;

    // Reset values of the configuration registers
    localparam logic [SPEED_W-1:0] TARGET_RESET = '0;
    localparam logic [DIV_W-1:0]   PROP_RESET   = 12'd2048;
    localparam logic [DIV_W-1:0]   DERIV_RESET  = 12'd256;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET = 2'd0,
        CFG_PROP   = 2'd1,
        CFG_DERIV  = 2'd2
    } cfg_index_t;

    // Input item kinds
    localparam logic KIND_MEASURE = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

endpackage

// ----- hw/rtl/incremental_pd_speed_regulator.sv -----
// Top level of the incremental PD speed regulator.
// Depends on ipd_pkg for widths, register indexes and constants.
//
// Usage:
//   Input beats arrive on the s_ channel: tuser carries the kind (measurement
//   tick or restart) and tdata carries the measured speed. Every input beat
//   yields exactly one result beat on the m_ channel with the drive level and
//   the reported speed. Registers are written through the cfg_ channel, which
//   is always ready; write them only while the block is idle.
//   A measurement beat runs two serial divisions on one shared restoring
//   divider, one quotient bit per cycle, then a scaling and clamping state
//   (ST_SCALE) and an output load state (ST_OUT). s_tready rises in the same
//   cycle as the result shows, so the next beat can be taken once the result
//   is loaded. A restart beat needs no division and goes straight to the
//   output load state.
//   The block works on one item at a time; s_tready is high only in the idle
//   state. A result waits in the output register while m_tready is low, and a
//   finished result is held back until the previous one has been taken.
//   Reset (aresetn low, synchronous) clears the drive level and the previous
//   measurement, restores the register defaults and empties the output.
module incremental_pd_speed_regulator
    import ipd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DAT_W-1:0]  cfg_data,
    // Input channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // [13:0] measured_speed, [15:14] zero
    input  logic                  s_tuser,   // [0] kind
    // Result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata    // [15:0] drive_level, [31:16] reported_speed
);

    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int REM_W     = DIV_W + 1;
    localparam int TERM_W    = QUO_W + 2;
    localparam int SUM_W     = TERM_W + 1;
    localparam int DELTA_W   = SUM_W - 8;
    localparam int NEXT_W    = DELTA_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCALE,
        ST_OUT
    } state_t;

    // Control state
    state_t                   state_reg, state_next;
    logic                     phase_reg, phase_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     m_tvalid_reg, m_tvalid_next;

    // Configuration and regulator state
    logic [SPEED_W-1:0]       target_reg;
    logic [DIV_W-1:0]         prop_reg;
    logic [DIV_W-1:0]         deriv_reg;
    logic signed [DRIVE_W-1:0] drive_reg, drive_next;
    logic [SPEED_W-1:0]       prev_reg, prev_next;

    // Divider and datapath registers
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [QUO_W-1:0]         quo_reg, quo_next;
    logic [DIV_W-1:0]         q_reg, q_next;
    logic                     neg_reg, neg_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [SPEED_W-1:0]       meas_reg, meas_next;
    logic [M_DATA_W-1:0]      m_tdata_reg, m_tdata_next;

    // Combinational helpers
    logic                     s_accept;
    logic signed [SPEED_W:0]  diff_p, diff_d;
    logic [REM_W-1:0]         shifted;
    logic                     ge;
    logic [QUO_W-1:0]         quo_step;
    logic signed [TERM_W-1:0] term;
    logic [SUM_W-1:0]         sum_mag;
    logic [DELTA_W-1:0]       delta_mag;
    logic signed [DELTA_W-1:0] delta;
    logic signed [NEXT_W-1:0] drive_wide;
    logic signed [DRIVE_W-1:0] drive_clamped, report;

    // A zero divisor acts as the smallest step
    function automatic logic [DIV_W-1:0] eff_div(input logic [DIV_W-1:0] q);
        return (q == '0) ? DIV_W'(1) : q;
    endfunction

    // Magnitude of a signed speed difference
    function automatic logic [SPEED_W-1:0] mag_of(input logic signed [SPEED_W:0] d);
        logic signed [SPEED_W:0] m;
        m = d[SPEED_W] ? -d : d;
        return m[SPEED_W-1:0];
    endfunction

    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Speed differences for the two terms
    assign diff_p = $signed({1'b0, target_reg}) - $signed({1'b0, s_tdata[SPEED_W-1:0]});
    assign diff_d = $signed({1'b0, prev_reg}) - $signed({1'b0, meas_reg});

    // One restoring division step
    assign shifted  = {rem_reg[DIV_W-1:0], quo_reg[QUO_W-1]};
    assign ge       = (shifted >= {1'b0, q_reg});
    assign quo_step = {quo_reg[QUO_W-2:0], ge};
    assign term     = neg_reg ? -$signed({2'b00, quo_step}) : $signed({2'b00, quo_step});

    // Scale the sum to an integer, truncating toward zero, then accumulate
    assign sum_mag    = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign delta_mag  = sum_mag[SUM_W-1:8];
    assign delta      = sum_reg[SUM_W-1] ? -$signed(delta_mag) : $signed(delta_mag);
    assign drive_wide = NEXT_W'(drive_reg) + NEXT_W'(delta);

    always_comb begin
        if (drive_wide >= NEXT_W'(DRIVE_CEILING)) begin
            drive_clamped = DRIVE_CEILING;
        end else if (drive_wide < -$signed(NEXT_W'(32768))) begin
            drive_clamped = {1'b1, {(DRIVE_W-1){1'b0}}};
        end else begin
            drive_clamped = drive_wide[DRIVE_W-1:0];
        end
    end

    assign report = (drive_reg == '0) ? DRIVE_W'(1) : drive_reg;

    // Sequencer and datapath next values
    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        drive_next    = drive_reg;
        prev_next     = prev_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        q_next        = q_reg;
        neg_next      = neg_reg;
        sum_next      = sum_reg;
        meas_next     = meas_reg;
        m_tdata_next  = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    meas_next = s_tdata[SPEED_W-1:0];
                    if (s_tuser == KIND_RESTART) begin
                        drive_next = DRIVE_W'(target_reg);
                        prev_next  = '0;
                        state_next = ST_OUT;
                    end else begin
                        // Start the proportional division
                        rem_next   = '0;
                        quo_next   = {mag_of(diff_p), {FRAC_SHIFT{1'b0}}};
                        neg_next   = diff_p[SPEED_W];
                        q_next     = eff_div(prop_reg);
                        phase_next = 1'b0;
                        cnt_next   = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                rem_next = ge ? (shifted - {1'b0, q_reg}) : shifted;
                quo_next = quo_step;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    cnt_next = '0;
                    if (!phase_reg) begin
                        // Keep the proportional term, start the derivative one
                        sum_next   = SUM_W'(term);
                        rem_next   = '0;
                        quo_next   = {mag_of(diff_d), {FRAC_SHIFT{1'b0}}};
                        neg_next   = diff_d[SPEED_W];
                        q_next     = eff_div(deriv_reg);
                        phase_next = 1'b1;
                    end else begin
                        sum_next   = sum_reg + SUM_W'(term);
                        state_next = ST_SCALE;
                    end
                end
            end
            ST_SCALE: begin
                drive_next = drive_clamped;
                prev_next  = meas_reg;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = {report, drive_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, registered outputs and regulator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= 1'b0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            drive_reg    <= '0;
            prev_reg     <= '0;
            target_reg   <= TARGET_RESET;
            prop_reg     <= PROP_RESET;
            deriv_reg    <= DERIV_RESET;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            drive_reg    <= drive_next;
            prev_reg     <= prev_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_addr)
                    CFG_TARGET: target_reg <= cfg_data[SPEED_W-1:0];
                    CFG_PROP:   prop_reg   <= cfg_data[DIV_W-1:0];
                    CFG_DERIV:  deriv_reg  <= cfg_data[DIV_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath payload registers
    always_ff @(posedge aclk) begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        q_reg       <= q_next;
        neg_reg     <= neg_next;
        sum_reg     <= sum_next;
        meas_reg    <= meas_next;
        m_tdata_reg <= m_tdata_next;
    end

`ifndef NO_ASSERTIONS
    // An accepted beat always starts work that blocks the next one
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("input accepted on two consecutive cycles");

    // The remainder stays below the divisor throughout a division
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < {1'b0, q_reg}))
        else $error("divider remainder out of range");

    // The divider never sees a zero divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (q_reg != '0))
        else $error("zero divisor in divider");

    // A zero drive level is reported as speed one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:0] != '0 || m_tdata[31:16] == 16'd1))
        else $error("zero drive not reported as one");

    // A result is never overwritten before it has been taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("pending result lost");
`endif

endmodule

// ----- dv/tb_incremental_pd_speed_regulator.sv -----
// Self-checking testbench for the incremental PD speed regulator.
// Drives the input stream and register channel, predicts every result beat and compares it.
// Depends on ipd_pkg and the incremental_pd_speed_regulator top level.
`timescale 1ns / 100ps

module tb_incremental_pd_speed_regulator;
    import ipd_pkg::*;

    // Register index with no register behind it; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [SPEED_W-1:0]   SPEED_MAX = '1;
    localparam logic [DIV_W-1:0]     DIV_MAX   = '1;
    localparam longint               DRIVE_FLOOR = -32768;
    localparam int                   REPORT_CAP  = 100;

    // Expected result beat; drive level sits in the low half of tdata.
    typedef struct packed {
        logic signed [DRIVE_W-1:0] report;
        logic signed [DRIVE_W-1:0] drive;
    } drive_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;   // [13:0] measured_speed, [15:14] zero
    logic                 s_tuser = 1'b0; // [0] kind
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;        // [15:0] drive_level, [31:16] reported_speed

    // Predictor state and register copies.
    logic [SPEED_W-1:0]        target_q = TARGET_RESET;
    logic [DIV_W-1:0]          prop_div_q = PROP_RESET;
    logic [DIV_W-1:0]          deriv_div_q = DERIV_RESET;
    logic signed [DRIVE_W-1:0] drive_q = '0;
    logic [SPEED_W-1:0]        last_speed_q = '0;

    drive_result_t pending_drive_q[$];

    // Traffic shaping knobs for the source gaps and the receiver process.
    bit src_idle_en = 1'b1;
    bit sink_idle_en = 1'b1;
    int sink_hold = 0;

    int fail_count = 0;
    int result_count = 0;
    int measure_count = 0;
    int restart_count = 0;
    int write_count = 0;

    incremental_pd_speed_regulator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock generation.
    initial begin
        forever #6 aclk = ~aclk;
    end

    // Overall time limit.
    initial begin
        #50_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // One speed difference over a Q4.8 divisor, kept with 8 fraction bits.
    function automatic longint frac_term(input longint diff, input logic [DIV_W-1:0] divisor);
        longint q;
        q = (divisor == '0) ? 64'sd1 : longint'(divisor);
        return (diff * 65536) / q;
    endfunction

    // Advances the drive model by one accepted beat and returns the expected result.
    task automatic advance_regulator(input logic kind, input logic [SPEED_W-1:0] speed,
                                     output drive_result_t res);
        longint p_term;
        longint d_term;
        longint next_drive;
        if (kind == KIND_RESTART) begin
            drive_q = DRIVE_W'(target_q);
            last_speed_q = '0;
            restart_count++;
        end else begin
            p_term = frac_term(longint'(target_q) - longint'(speed), prop_div_q);
            d_term = frac_term(longint'(last_speed_q) - longint'(speed), deriv_div_q);
            next_drive = longint'(drive_q) + (p_term + d_term) / 256;
            if (next_drive >= longint'(DRIVE_CEILING))
                next_drive = longint'(DRIVE_CEILING);
            if (next_drive < DRIVE_FLOOR)
                next_drive = DRIVE_FLOOR;
            drive_q = next_drive[DRIVE_W-1:0];
            last_speed_q = speed;
            measure_count++;
        end
        res.drive = drive_q;
        res.report = (drive_q == '0) ? 16'sd1 : drive_q;
    endtask

    // Gap before an input beat: often none, mostly short, now and then long.
    function automatic int src_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!src_idle_en || r < 50)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 90);
    endfunction

    // Receiver: a requested hold-off first, then random stalls.
    initial begin
        int stall_left;
        int r;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (sink_hold > 0) begin
                m_tready <= 1'b0;
                sink_hold--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                    r = $urandom_range(0, 99);
                    stall_left = (r < 90) ? $urandom_range(1, 4) : $urandom_range(20, 80);
                end
            end
        end
    end

    task automatic note_failure(input string field, input int want, input int got);
        fail_count++;
        if (fail_count <= REPORT_CAP)
            $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    endtask

    // Result checker: each result beat against the oldest expectation.
    always @(posedge aclk) begin : check_results
        drive_result_t got;
        drive_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            result_count++;
            if (pending_drive_q.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_CAP)
                    $display("%0t ns: unexpected result: expected none, actual drive %0d",
                             $time, got.drive);
            end else begin
                want = pending_drive_q.pop_front();
                if (got.drive !== want.drive)
                    note_failure("drive_level", want.drive, got.drive);
                if (got.report !== want.report)
                    note_failure("reported_speed", want.report, got.report);
            end
        end
    end

    // Sends one input beat after an optional gap and records its expected result.
    task automatic send_item(input logic kind, input logic [SPEED_W-1:0] speed, input int gap);
        drive_result_t res;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= S_DATA_W'(speed);
        do @(posedge aclk); while (!s_tready);
        advance_regulator(kind, speed, res);
        pending_drive_q.push_back(res);
    endtask

    // Stops offering input and waits until every expected result has arrived.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_drive_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Register write; the block is drained first so it is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        drain_results();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_TARGET: target_q = data[SPEED_W-1:0];
            CFG_PROP:   prop_div_q = data[DIV_W-1:0];
            CFG_DERIV:  deriv_div_q = data[DIV_W-1:0];
            default: ;
        endcase
        write_count++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Reset values: zero target, divisors 8.0 and 1.0; large steps drive the level negative.
    task automatic test_reset_defaults();
        send_item(KIND_MEASURE, '0, 0);
        send_item(KIND_MEASURE, SPEED_MAX, 0);
        send_item(KIND_MEASURE, SPEED_MAX, 1);
        send_item(KIND_MEASURE, 14'd1, 0);
        send_item(KIND_MEASURE, 14'h2000, 2);
        drain_results();
    endtask

    // Restart loads the target unclamped; a zero drive reports 1; big gains hit the ceiling.
    task automatic test_restart_and_ceiling();
        send_item(KIND_RESTART, SPEED_MAX, 0);
        write_reg(CFG_TARGET, 14'h3FFF);
        send_item(KIND_RESTART, '0, 0);
        send_item(KIND_MEASURE, SPEED_MAX, 0);
        send_item(KIND_MEASURE, '0, 0);
        send_item(KIND_MEASURE, 14'd799, 3);
        drain_results();
    endtask

    // Zero divisors act as the smallest step; upper data bits of a divisor are dropped.
    task automatic test_divisor_extremes();
        write_reg(CFG_TARGET, 14'd100);
        write_reg(CFG_PROP, 14'h3000);
        write_reg(CFG_DERIV, 14'(DIV_MAX));
        send_item(KIND_RESTART, 14'h1555, 0);
        send_item(KIND_MEASURE, 14'd101, 0);
        send_item(KIND_MEASURE, 14'd99, 0);
        send_item(KIND_MEASURE, SPEED_MAX, 0);
        write_reg(CFG_PROP, 14'(DIV_MAX));
        write_reg(CFG_DERIV, '0);
        send_item(KIND_MEASURE, '0, 0);
        send_item(KIND_MEASURE, SPEED_MAX, 0);
        // A write to the spare index must leave every register alone.
        write_reg(CFG_SPARE, 14'h3FFF);
        send_item(KIND_RESTART, '0, 0);
        send_item(KIND_MEASURE, 14'd50, 0);
        write_reg(CFG_PROP, 14'd1);
        write_reg(CFG_DERIV, 14'd1);
        send_item(KIND_MEASURE, 14'd10, 0);
        drain_results();
    endtask

    // Random phases: new settings, a restart, then speeds around the target with some noise.
    task automatic test_random_phases(input int total);
        int sent;
        int run_len;
        int span;
        int r;
        int speed;
        int tgt;
        sent = 0;
        while (sent < total) begin
            r = $urandom_range(0, 9);
            tgt = (r == 0) ? 0 : (r == 1) ? 16383 : (r == 2) ? 800 : $urandom_range(0, 16383);
            write_reg(CFG_TARGET, 14'(tgt));
            r = $urandom_range(0, 9);
            write_reg(CFG_PROP, {2'($urandom_range(0, 3)),
                                 (r == 0) ? 12'd0 : (r == 1) ? 12'd1 : (r == 2) ? DIV_MAX :
                                 12'($urandom_range(1, 4095))});
            r = $urandom_range(0, 9);
            write_reg(CFG_DERIV, {2'($urandom_range(0, 3)),
                                  (r == 0) ? 12'd0 : (r == 1) ? 12'd1 : (r == 2) ? DIV_MAX :
                                  12'($urandom_range(1, 4095))});
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_SPARE, 14'($urandom));
            r = $urandom_range(0, 2);
            span = (r == 0) ? 8 : (r == 1) ? 64 : 1024;
            send_item(KIND_RESTART, 14'($urandom), src_gap());
            sent++;
            run_len = $urandom_range(60, 140);
            for (int i = 0; i < run_len && sent < total; i++) begin
                r = $urandom_range(0, 99);
                if (r < 85) begin
                    speed = tgt + $urandom_range(0, 2 * span) - span;
                    if (speed < 0)
                        speed = 0;
                    if (speed > 16383)
                        speed = 16383;
                    send_item(KIND_MEASURE, 14'(speed), src_gap());
                end else if (r < 95) begin
                    send_item(KIND_MEASURE, 14'($urandom), src_gap());
                end else begin
                    send_item(KIND_RESTART, 14'($urandom), src_gap());
                end
                sent++;
            end
            drain_results();
        end
    endtask

    // The receiver holds off for a long stretch while input keeps coming.
    task automatic test_output_holdoff();
        @(negedge aclk);
        sink_hold = 300;
        for (int i = 0; i < 20; i++)
            send_item(($urandom_range(0, 4) == 0) ? KIND_RESTART : KIND_MEASURE,
                      14'($urandom), 0);
        drain_results();
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_no_idle();
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        for (int i = 0; i < 60; i++)
            send_item(($urandom_range(0, 5) == 0) ? KIND_RESTART : KIND_MEASURE,
                      14'($urandom), 0);
        drain_results();
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    // Test sequence.
    initial begin
        int waited;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_restart_and_ceiling();
        test_divisor_extremes();
        test_output_holdoff();
        test_random_phases(1550);
        test_no_idle();

        // Let any stray result show up before the verdict.
        @(negedge aclk);
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_drive_q.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (80) @(posedge aclk);
        if (pending_drive_q.size() != 0) begin
            fail_count++;
            $display("%0t ns: %0d expected results never arrived", $time,
                     pending_drive_q.size());
        end

        $display("Checked %0d results from %0d measurement and %0d restart beats, %0d writes.",
                 result_count, measure_count, restart_count, write_count);
        $display("Covered zero and maximal divisors, both drive limits and a long output stall.");
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
